[hw/rtl/lsp_pkg.sv]
// lsp_pkg: shared constants, operation and status codes and types for the lifo stack
// used by every file of the block; depends on nothing
package lsp_pkg;

    // storage geometry
    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 4;
    localparam int ST_W   = 2;

    // request codes
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEP     = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // request transfer: execute it and load the first result
        logic step;    // load the next traverse result
    } lsp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic trav_multi;  // request on the input is a traverse with more than one entry
        logic idx_zero;    // traverse has reached the bottom entry
    } lsp_stat_t;

endpackage

[hw/rtl/lsp_req_if.sv]
// lsp_req_if: request channel of the lifo stack (valid, ready, payload)
// depends on lsp_pkg
interface lsp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [lsp_pkg::OP_W-1:0]             op;
    logic signed [lsp_pkg::DATA_W-1:0]    push_value;
    logic [lsp_pkg::POS_W-1:0]            position;

    modport source (output valid, output op, output push_value, output position, input ready);
    modport sink   (input valid, input op, input push_value, input position, output ready);
endinterface

[hw/rtl/lsp_rsp_if.sv]
// lsp_rsp_if: result channel of the lifo stack (valid, ready, payload)
// depends on lsp_pkg
interface lsp_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lsp_pkg::DATA_W-1:0]    data;
    logic [lsp_pkg::ST_W-1:0]             status;
    logic [lsp_pkg::CNT_W-1:0]            depth_now;
    logic                                 last;

    modport source (output valid, output data, output status, output depth_now, output last,
                    input ready);
    modport sink   (input valid, input data, input status, input depth_now, input last,
                    output ready);
endinterface

[hw/rtl/lsp_ctrl.sv]
// lsp_ctrl: handshake and sequencing controller of the lifo stack
// depends on lsp_pkg; drives the datapath through lsp_cmd_t
module lsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lsp_pkg::lsp_stat_t stat,
    output lsp_pkg::lsp_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic accept;

    // output register can take a new result this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd.start  = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    if (stat.trav_multi)
                    begin
                        state_next = S_TRAV;
                    end
                end
            end
            S_TRAV:
            begin
                if (out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.start || cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/lsp_dpath.sv]
// lsp_dpath: entry store, fill count, traverse index and result register of the lifo stack
// depends on lsp_pkg; commanded by lsp_ctrl
module lsp_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lsp_pkg::OP_W-1:0]          op,
    input  logic signed [lsp_pkg::DATA_W-1:0] push_value,
    input  logic [lsp_pkg::POS_W-1:0]         position,
    input  lsp_pkg::lsp_cmd_t                 cmd,
    output lsp_pkg::lsp_stat_t                stat,
    output logic signed [lsp_pkg::DATA_W-1:0] data,
    output logic [lsp_pkg::ST_W-1:0]          status,
    output logic [lsp_pkg::CNT_W-1:0]         depth_now,
    output logic                              last
);

    logic signed [lsp_pkg::DATA_W-1:0] entries_reg [lsp_pkg::DEPTH];
    logic [lsp_pkg::CNT_W-1:0]         count_reg;
    logic [lsp_pkg::CNT_W-1:0]         count_next;
    logic [lsp_pkg::IDX_W-1:0]         idx_reg;
    logic [lsp_pkg::IDX_W-1:0]         idx_next;

    logic signed [lsp_pkg::DATA_W-1:0] data_reg;
    logic signed [lsp_pkg::DATA_W-1:0] data_next;
    logic [lsp_pkg::ST_W-1:0]          status_reg;
    logic [lsp_pkg::ST_W-1:0]          status_next;
    logic [lsp_pkg::CNT_W-1:0]         depth_reg;
    logic [lsp_pkg::CNT_W-1:0]         depth_next;
    logic                              last_reg;
    logic                              last_next;

    logic [lsp_pkg::CNT_W-1:0]         rd_full;
    logic [lsp_pkg::IDX_W-1:0]         rd_addr;
    logic signed [lsp_pkg::DATA_W-1:0] rd_data;
    logic                              is_empty;
    logic                              is_full;
    logic                              wr_en;
    logic [lsp_pkg::CNT_W-1:0]         top_full;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= lsp_pkg::CNT_W'(lsp_pkg::DEPTH));
    assign top_full = count_reg - lsp_pkg::CNT_W'(1);

    // status towards the controller
    assign stat.trav_multi = (op == lsp_pkg::OP_TRAVERSE) && (count_reg > lsp_pkg::CNT_W'(1));
    assign stat.idx_zero   = (idx_reg == '0);

    // single read port address
    always_comb
    begin
        if (cmd.step)
        begin
            rd_full = lsp_pkg::CNT_W'(idx_reg);
        end
        else if (op == lsp_pkg::OP_PEEP)
        begin
            rd_full = count_reg - position;
        end
        else
        begin
            rd_full = top_full;
        end
    end

    assign rd_addr = rd_full[lsp_pkg::IDX_W-1:0];
    assign rd_data = entries_reg[rd_addr];

    // request execution and next result
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        data_next   = data_reg;
        status_next = status_reg;
        depth_next  = depth_reg;
        last_next   = last_reg;
        if (cmd.step)
        begin
            data_next   = rd_data;
            status_next = lsp_pkg::ST_OK;
            depth_next  = count_reg;
            last_next   = (idx_reg == '0);
            idx_next    = idx_reg - lsp_pkg::IDX_W'(1);
        end
        else if (cmd.start)
        begin
            data_next   = '0;
            status_next = lsp_pkg::ST_OK;
            last_next   = 1'b1;
            case (op)
                lsp_pkg::OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = lsp_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + lsp_pkg::CNT_W'(1);
                    end
                end
                lsp_pkg::OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = lsp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next  = rd_data;
                        count_next = top_full;
                    end
                end
                lsp_pkg::OP_TRAVERSE:
                begin
                    if (is_empty)
                    begin
                        status_next = lsp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next = rd_data;
                        last_next = (count_reg == lsp_pkg::CNT_W'(1));
                        idx_next  = rd_addr - lsp_pkg::IDX_W'(1);
                    end
                end
                lsp_pkg::OP_PEEP:
                begin
                    if ((position == '0) || (position > count_reg))
                    begin
                        status_next = lsp_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        data_next = rd_data;
                    end
                end
                lsp_pkg::OP_PEEK:
                begin
                    if (is_empty)
                    begin
                        status_next = lsp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next = rd_data;
                    end
                end
                default:
                begin
                    status_next = lsp_pkg::ST_OK;
                end
            endcase
            depth_next = count_next;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entry store and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[count_reg[lsp_pkg::IDX_W-1:0]] <= push_value;
        end
        idx_reg    <= idx_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
        last_reg   <= last_next;
    end

    assign data      = data_reg;
    assign status    = status_reg;
    assign depth_now = depth_reg;
    assign last      = last_reg;

endmodule

[hw/rtl/lifo_stack_with_peep.sv]
// lifo_stack_with_peep: bounded lifo store of signed words with push, pop, peek, peep, traverse
// result: a request's first result is in the output register in the cycle after its transfer
// throughput: one request per cycle for push, pop, peek and peep while results are taken;
// traverse holds the request side until the single entry read port has given every entry
// reset: asynchronous active low, empties the store; entry contents are left unset
module lifo_stack_with_peep (
    input logic       clk,
    input logic       rst_n,
    lsp_req_if.sink   req,
    lsp_rsp_if.source rsp
);

    lsp_pkg::lsp_cmd_t  cmd;
    lsp_pkg::lsp_stat_t stat;

    // sequencing and handshakes
    lsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store, count and result register
    lsp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (req.op),
        .push_value (req.push_value),
        .position   (req.position),
        .cmd        (cmd),
        .stat       (stat),
        .data       (rsp.data),
        .status     (rsp.status),
        .depth_now  (rsp.depth_now),
        .last       (rsp.last)
    );

endmodule
